// ===== rtl/core/tpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, constants and helpers of the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int unsigned NumCfg  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = 1;
  localparam int unsigned QCntW   = 2;
  localparam int unsigned DivSteps = 33;
  localparam int unsigned DivCntW  = 6;

  localparam logic [CfgIdxW-1:0] CfgPointX  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPointY  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPointZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgNormalX = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNormalY = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgNormalZ = 3'd5;

  localparam logic [31:0] NormalZReset = 32'h0001_0000;

  // x, y, z, w at index 0..3
  typedef logic [3:0][31:0] vtx_t;

  typedef struct packed {
    vtx_t [2:0]       v;
    logic [2:0][31:0] d;
    logic [15:0]      color;
    logic [15:0]      symbol;
  } job_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_front
// Plane registers, vertex capture and plane distance; hands finished
// triangles to the job queue.
// ----------------------------------------------------------------------------
module tpc_front #(
  parameter int unsigned CoordFracBits = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [31:0]                  vx_i,
  input  logic [31:0]                  vy_i,
  input  logic [31:0]                  vz_i,
  input  logic [31:0]                  vw_i,
  input  logic [15:0]                  tri_color_i,
  input  logic [15:0]                  tri_symbol_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output logic                         push_o,
  output tpc_pkg::job_t                job_o,
  input  logic                         full_i
);

  localparam logic [1:0] FsIdle = 2'd0;
  localparam logic [1:0] FsCalc = 2'd1;
  localparam logic [1:0] FsDone = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [2:0][31:0]  cfg_p_q, cfg_n_q;
  logic [1:0]        cnt_q;
  logic [1:0]        step_q;
  tpc_pkg::vtx_t     cur_q;
  logic [15:0]       col_q, sym_q;
  tpc_pkg::vtx_t [1:0] store_q;
  logic [1:0][31:0]  dist_q;
  logic signed [63:0] prod_q;
  logic signed [33:0] acc_q;

  logic [1:0]         comp;
  logic signed [32:0] diff_w;
  logic signed [31:0] diff_s;
  logic signed [31:0] term;
  logic [31:0]        dcur;
  logic               accept;

  assign accept      = start_i && (state_q == FsIdle);
  assign busy_o      = (state_q != FsIdle);
  assign cfg_ready_o = 1'b1;

  assign comp   = (step_q == 2'd3) ? 2'd2 : step_q;
  assign diff_w = $signed({cur_q[comp][31], cur_q[comp]})
                - $signed({cfg_p_q[comp][31], cfg_p_q[comp]});
  assign diff_s = $signed(tpc_pkg::sat32(66'(diff_w)));
  assign term   = $signed(tpc_pkg::sat32(66'(prod_q >>> CoordFracBits)));
  assign dcur   = tpc_pkg::sat32(66'(acc_q));

  assign push_o      = (state_q == FsDone) && (cnt_q == 2'd2) && !full_i;
  assign job_o.v     = {cur_q, store_q[1], store_q[0]};
  assign job_o.d     = {dcur, dist_q[1], dist_q[0]};
  assign job_o.color  = col_q;
  assign job_o.symbol = sym_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FsIdle: if (accept) state_d = FsCalc;
      FsCalc: if (step_q == 2'd3) state_d = FsDone;
      FsDone: if (cnt_q != 2'd2 || !full_i) state_d = FsIdle;
      default: state_d = FsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsIdle;
      cnt_q   <= 2'd0;
      step_q  <= 2'd0;
      cfg_p_q <= '0;
      cfg_n_q <= {tpc_pkg::NormalZReset, 32'd0, 32'd0};
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tpc_pkg::CfgPointX:  cfg_p_q[0] <= cfg_data_i;
          tpc_pkg::CfgPointY:  cfg_p_q[1] <= cfg_data_i;
          tpc_pkg::CfgPointZ:  cfg_p_q[2] <= cfg_data_i;
          tpc_pkg::CfgNormalX: cfg_n_q[0] <= cfg_data_i;
          tpc_pkg::CfgNormalY: cfg_n_q[1] <= cfg_data_i;
          tpc_pkg::CfgNormalZ: cfg_n_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        step_q <= 2'd0;
      end else if (state_q == FsCalc) begin
        step_q <= step_q + 2'd1;
      end
      if (state_q == FsDone) begin
        if (cnt_q != 2'd2) begin
          cnt_q <= cnt_q + 2'd1;
        end else if (!full_i) begin
          cnt_q <= 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= {vw_i, vz_i, vy_i, vx_i};
      col_q <= tri_color_i;
      sym_q <= tri_symbol_i;
      acc_q <= '0;
    end
    if (state_q == FsCalc) begin
      // product of one component per cycle, summed in the following cycle
      if (step_q != 2'd3) prod_q <= $signed(cfg_n_q[comp]) * diff_s;
      if (step_q != 2'd0) acc_q <= acc_q + 34'(term);
    end
    if (state_q == FsDone && cnt_q != 2'd2) begin
      store_q[cnt_q[0]] <= cur_q;
      dist_q[cnt_q[0]]  <= dcur;
    end
  end

endmodule

// ===== rtl/core/tpc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_queue
// Two-entry job queue between the distance front and the clipping back.
// ----------------------------------------------------------------------------
module tpc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpc_pkg::job_t data_i,
  input  logic          pop_i,
  output tpc_pkg::job_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  tpc_pkg::job_t                   entries_q [tpc_pkg::QDepth];
  logic [tpc_pkg::QPtrW-1:0]       wr_q, rd_q;
  logic [tpc_pkg::QCntW-1:0]       cnt_q;

  assign full_o  = (cnt_q == tpc_pkg::QCntW'(tpc_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entries_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_q] <= data_i;
  end

endmodule

// ===== rtl/core/tpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_back
// Classifies a queued triangle, computes edge cut points with one
// multiplier and a bit-serial divider, and streams the output vertices.
// ----------------------------------------------------------------------------
module tpc_back #(
  parameter int unsigned CoordFracBits = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  tpc_pkg::job_t job_i,
  output logic          pop_o,
  output logic          valid_o,
  output logic [31:0]   ox_o,
  output logic [31:0]   oy_o,
  output logic [31:0]   oz_o,
  output logic [31:0]   ow_o,
  output logic [15:0]   out_color_o,
  output logic [15:0]   out_symbol_o,
  output logic          end_of_triangle_o,
  output logic          last_o
);

  localparam logic [2:0] BsIdle  = 3'd0;
  localparam logic [2:0] BsClass = 3'd1;
  localparam logic [2:0] BsMul   = 3'd2;
  localparam logic [2:0] BsPrep  = 3'd3;
  localparam logic [2:0] BsDiv   = 3'd4;
  localparam logic [2:0] BsFix   = 3'd5;
  localparam logic [2:0] BsEmit  = 3'd6;

  localparam logic [1:0] SrcVtx  = 2'd0;
  localparam logic [1:0] SrcCutA = 2'd1;
  localparam logic [1:0] SrcCutB = 2'd2;

  localparam logic [31:0] WOne = 32'(1) << CoordFracBits;

  logic [2:0]          state_q;
  tpc_pkg::job_t       job_q;
  tpc_pkg::vtx_t [1:0] cut_q;
  logic                cut_sel_q;
  logic [1:0]          comp_q;
  logic signed [65:0]  prod_q;
  logic                neg_q;
  logic [32:0]         rem_q, low_q, quo_q, den_q;
  logic [tpc_pkg::DivCntW-1:0] bit_q;
  logic [2:0]          step_q;
  logic                valid_q;

  logic [2:0]          in_m;
  logic [1:0]          ni;
  logic [1:0]          ins0, ins1, out0, out1;
  logic [1:0]          s_idx, e_idx;
  logic [31:0]         ds, de, sc, ec;
  logic signed [32:0]  delta, den;
  logic [65:0]         mag;
  logic [33:0]         trial;
  logic                ge;
  logic [32:0]         qs;
  logic [1:0]          src;
  logic [1:0]          vidx;
  tpc_pkg::vtx_t       sel_v;
  logic                is_last, is_eot;

  always_comb begin
    logic seen_in, seen_out;
    seen_in  = 1'b0;
    seen_out = 1'b0;
    ins0 = 2'd0;
    ins1 = 2'd0;
    out0 = 2'd0;
    out1 = 2'd0;
    for (int i = 0; i < 3; i++) begin
      in_m[i] = ~job_q.d[i][31];
      if (in_m[i]) begin
        if (!seen_in) ins0 = 2'(i);
        else          ins1 = 2'(i);
        seen_in = 1'b1;
      end else begin
        if (!seen_out) out0 = 2'(i);
        else           out1 = 2'(i);
        seen_out = 1'b1;
      end
    end
  end

  assign ni = 2'(in_m[0]) + 2'(in_m[1]) + 2'(in_m[2]);

  // one inside: cuts in0->out0, in0->out1; two inside: in0->out0, in1->out0
  assign s_idx = (ni == 2'd2 && cut_sel_q) ? ins1 : ins0;
  assign e_idx = (ni == 2'd1 && cut_sel_q) ? out1 : out0;
  assign ds    = job_q.d[s_idx];
  assign de    = job_q.d[e_idx];
  assign sc    = job_q.v[s_idx][comp_q];
  assign ec    = job_q.v[e_idx][comp_q];
  assign delta = $signed({ec[31], ec}) - $signed({sc[31], sc});
  assign den   = $signed({ds[31], ds}) - $signed({de[31], de});

  assign mag   = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
  assign trial = {rem_q, low_q[32]};
  assign ge    = (trial >= {1'b0, den_q});
  assign qs    = neg_q ? 33'(-quo_q) : quo_q;

  always_comb begin
    src  = SrcVtx;
    vidx = step_q[1:0];
    case (ni)
      2'd2: begin
        case (step_q)
          3'd0: vidx = ins0;
          3'd1: vidx = ins1;
          3'd2: src  = SrcCutA;
          3'd3: vidx = ins1;
          3'd4: src  = SrcCutA;
          default: src = SrcCutB;
        endcase
      end
      2'd1: begin
        case (step_q)
          3'd0: vidx = ins0;
          3'd1: src  = SrcCutA;
          default: src = SrcCutB;
        endcase
      end
      default: ;
    endcase
    case (src)
      SrcCutA: sel_v = cut_q[0];
      SrcCutB: sel_v = cut_q[1];
      default: sel_v = job_q.v[vidx];
    endcase
  end

  assign is_last = (ni == 2'd2) ? (step_q == 3'd5) : (step_q == 3'd2);
  assign is_eot  = (step_q == 3'd2) || (step_q == 3'd5);

  assign pop_o   = (state_q == BsIdle) && !empty_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BsIdle;
      valid_q   <= 1'b0;
      cut_sel_q <= 1'b0;
      comp_q    <= 2'd0;
      bit_q     <= '0;
      step_q    <= 3'd0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        BsIdle: if (!empty_i) state_q <= BsClass;
        BsClass: begin
          cut_sel_q <= 1'b0;
          comp_q    <= 2'd0;
          step_q    <= 3'd0;
          if (ni == 2'd0) begin
            state_q <= BsIdle;
          end else if (ni == 2'd3) begin
            state_q <= BsEmit;
          end else begin
            state_q <= BsMul;
          end
        end
        BsMul:  state_q <= BsPrep;
        BsPrep: begin
          bit_q   <= '0;
          state_q <= BsDiv;
        end
        BsDiv: begin
          bit_q <= bit_q + 1'b1;
          if (bit_q == tpc_pkg::DivCntW'(tpc_pkg::DivSteps - 1)) state_q <= BsFix;
        end
        BsFix: begin
          if (comp_q == 2'd2) begin
            comp_q <= 2'd0;
            if (cut_sel_q) begin
              state_q <= BsEmit;
            end else begin
              cut_sel_q <= 1'b1;
              state_q   <= BsMul;
            end
          end else begin
            comp_q  <= comp_q + 2'd1;
            state_q <= BsMul;
          end
        end
        BsEmit: begin
          valid_q <= 1'b1;
          step_q  <= step_q + 3'd1;
          if (is_last) state_q <= BsIdle;
        end
        default: state_q <= BsIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    case (state_q)
      BsClass: begin
        cut_q[0][3] <= WOne;
        cut_q[1][3] <= WOne;
      end
      BsMul: begin
        prod_q <= delta * $signed({1'b0, ds});
        den_q  <= den;
      end
      BsPrep: begin
        // quotient never exceeds |delta|, so the top bits start below den
        neg_q <= prod_q[65];
        rem_q <= {2'b00, mag[63:33]};
        low_q <= mag[32:0];
        quo_q <= '0;
      end
      BsDiv: begin
        if (ge) rem_q <= 33'(trial - {1'b0, den_q});
        else    rem_q <= trial[32:0];
        low_q <= {low_q[31:0], 1'b0};
        quo_q <= {quo_q[31:0], ge};
      end
      BsFix: cut_q[cut_sel_q][comp_q] <= 32'({sc[31], sc} + qs);
      BsEmit: begin
        ox_o              <= sel_v[0];
        oy_o              <= sel_v[1];
        oz_o              <= sel_v[2];
        ow_o              <= sel_v[3];
        out_color_o       <= job_q.color;
        out_symbol_o      <= job_q.symbol;
        end_of_triangle_o <= is_eot;
        last_o            <= is_last;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/triangle_plane_clipper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_plane_clipper_core
// Clips triangles against a configured plane in Q fixed point.
// ----------------------------------------------------------------------------
// Usage:
// - Vertices enter on start while busy is low; three in a row make a triangle,
//   color and symbol are taken from the third.
// - Each vertex passes the front states FsCalc and FsDone (one distance
//   multiplier, one component per cycle); busy is high for that time and,
//   after a triangle's third vertex, while the two-entry job queue is full.
// - The back emits 0, 3 or 6 output words, one per cycle on valid_o, no
//   backpressure. A kept triangle goes from dequeue through BsClass to BsEmit;
//   a clipped one first computes 6 cut coordinates, each with a multiply,
//   then a 33-step bit-serial divider.
// - The plane registers are written on cfg_valid_i (cfg_ready_o is always
//   high); the user must do so only while the block is idle (not enforced).
// - Reset clears the vertex count, the queue and the plane (normal +z).
// ----------------------------------------------------------------------------
module triangle_plane_clipper_core #(
  parameter int unsigned CoordFracBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 vx_i,
  input  logic [31:0]                 vy_i,
  input  logic [31:0]                 vz_i,
  input  logic [31:0]                 vw_i,
  input  logic [15:0]                 tri_color_i,
  input  logic [15:0]                 tri_symbol_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  output logic                        valid_o,
  output logic [31:0]                 ox_o,
  output logic [31:0]                 oy_o,
  output logic [31:0]                 oz_o,
  output logic [31:0]                 ow_o,
  output logic [15:0]                 out_color_o,
  output logic [15:0]                 out_symbol_o,
  output logic                        end_of_triangle_o,
  output logic                        last_o
);

  logic          push, pop, full, empty;
  tpc_pkg::job_t push_job, pop_job;

  tpc_front #(.CoordFracBits(CoordFracBits)) u_front (
    .clk_i, .rst_ni,
    .start_i(start), .busy_o(busy),
    .vx_i, .vy_i, .vz_i, .vw_i, .tri_color_i, .tri_symbol_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push_o(push), .job_o(push_job), .full_i(full)
  );

  tpc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(push_job),
    .pop_i(pop), .data_o(pop_job),
    .full_o(full), .empty_o(empty)
  );

  tpc_back #(.CoordFracBits(CoordFracBits)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .job_i(pop_job), .pop_o(pop),
    .valid_o, .ox_o, .oy_o, .oz_o, .ow_o, .out_color_o, .out_symbol_o,
    .end_of_triangle_o, .last_o
  );

`ifndef SYNTHESIS
  a_last_ends_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> end_of_triangle_o)
    else $error("last word without end of triangle");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("output burst broken");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("front not busy after taking a vertex");
`endif

endmodule
